// ===== rtl/sha_pkg.sv =====
package sha_pkg;

	// Message geometry.
	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned NUM_ROUNDS  = 64;
	localparam logic [5:0]  LEN_POS     = 6'd56;
	localparam logic [5:0]  LAST_SLOT   = 6'd63;
	localparam logic [5:0]  LAST_ROUND  = 6'd63;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;

	// Eight chaining words, word 0 in the most significant position.
	typedef logic [0:7][31:0] chain_t;

	// One incoming request.
	typedef struct packed {
		logic [7:0] message_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_req_t;

	// One outgoing digest request.
	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} dig_req_t;

	// Controls from the sequencer to the compression core.
	typedef struct packed {
		logic       load;
		logic [7:0] data;
		logic       start;
		logic       init;
	} core_ctrl_t;

	// Initial hash values.
	localparam chain_t IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Round constants.
	localparam logic [31:0] K [NUM_ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Sigma functions of the round and the schedule.
	function automatic logic [31:0] big_s0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_s1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_s0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_s1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ===== rtl/sha_core.sv =====
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::core_ctrl_t ctrl,
	output logic               done,
	output sha_pkg::chain_t    chain
);
	import sha_pkg::*;

	logic [31:0] w_q [16];
	chain_t      wk_q;
	chain_t      chain_q;
	logic [5:0]  rnd_q;
	logic        run_q;
	logic        fin_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic [31:0] ch_v;
	logic [31:0] maj_v;

	// One round of the compression and the next schedule word.
	always_comb begin
		ch_v  = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
		maj_v = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
		t1    = wk_q[7] + big_s1(wk_q[4]) + ch_v + K[rnd_q] + w_q[0];
		t2    = big_s0(wk_q[0]) + maj_v;
		w_new = small_s1(w_q[14]) + w_q[9] + small_s0(w_q[1]) + w_q[0];
	end

	// Schedule window: bytes shift in while collecting, words roll during rounds.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i + 1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], ctrl.data};
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
	end

	// Working variables a to h.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			wk_q <= chain_q;
		end else if (run_q) begin
			wk_q <= {t1 + t2, wk_q[0], wk_q[1], wk_q[2],
				wk_q[3] + t1, wk_q[4], wk_q[5], wk_q[6]};
		end
	end

	// Round counter and completion step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (ctrl.start) begin
				rnd_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Chaining words: add the working words after the last round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= IV;
		end else if (ctrl.init) begin
			chain_q <= IV;
		end else if (fin_q) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= chain_q[i] + wk_q[i];
			end
		end
	end

	assign done  = fin_q;
	assign chain = chain_q;

	// A block is only started while the core is free.
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !run_q && !fin_q)
		else $error("compression started while busy");

	// The last round is followed by the chaining update.
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && rnd_q == LAST_ROUND |=> fin_q && !run_q)
		else $error("missing chaining update after last round");

	// The schedule window is never reloaded during rounds.
	a_no_load_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !ctrl.load && !ctrl.init)
		else $error("schedule or chaining disturbed during rounds");

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// SHA-256 stream hasher.
// Input channel msg: one request per message byte, with byte_present and
// end_of_message. A request with end_of_message closes the message; it may
// carry no byte, which allows an empty message. A request with neither flag
// is taken and has no effect.
// Output channel dig: four requests per message, the 256-bit digest in
// 64-bit words, word_number 0 (most significant) first, last_word on the
// fourth.
// Bytes are taken one per cycle while msg_stall is low. The byte that
// completes a 64-byte block raises msg_stall while the single shared round
// unit runs all rounds, then the chaining add. At message end the block
// appends padding one byte per cycle between compressions (9 to 72 bytes),
// with one or two further compressions.
// The digest sits in an output register, and the next message is taken while
// it drains; only a second digest waiting on a stalled receiver holds input.
// While dig_valid and dig_stall are both high, dig_valid and dig hold steady.
// Reset (arst_n low) clears the message state and loads the initial hash
// values; no request is pending afterward.
module sha256_stream_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sha_pkg::msg_req_t msg,
	output logic              dig_valid,
	input  logic              dig_stall,
	output sha_pkg::dig_req_t dig
);
	import sha_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_PAD  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic        last_pend_q;
	logic        pad_first_q;
	logic        final_blk_q;
	logic        last_blk_q;
	logic [255:0] dig_q;
	logic [1:0]  cnt_q;
	logic        busy_q;

	core_ctrl_t  ctrl;
	logic        done;
	chain_t      chain;

	logic        msg_acc;
	logic        dig_acc;
	logic        put;
	logic        full;
	logic        fb;
	logic        snap;
	logic [63:0] len_bits;
	logic [2:0]  lb_sel;
	logic [7:0]  pad_val;

	assign msg_stall = (state_q != ST_IDLE);
	assign msg_acc   = msg_valid && !msg_stall;
	assign dig_acc   = busy_q && !dig_stall;
	assign snap      = (state_q == ST_DONE) && !busy_q;

	// Padding byte: 0x80 first, then zeros, then the bit length big-endian.
	assign len_bits = {len_q[60:0], 3'b000};
	assign lb_sel   = ~fill_q[2:0];
	always_comb begin
		fb = pad_first_q ? (fill_q < LEN_POS) : final_blk_q;
		if (pad_first_q) begin
			pad_val = PAD_BYTE;
		end else if (fb && fill_q >= LEN_POS) begin
			pad_val = len_bits[{lb_sel, 3'b000} +: 8];
		end else begin
			pad_val = 8'h00;
		end
	end

	// Byte feed into the core.
	always_comb begin
		put       = 1'b0;
		ctrl.data = msg.message_byte;
		unique case (state_q)
			ST_IDLE: begin
				put = msg_acc && msg.byte_present;
			end
			ST_PAD: begin
				put       = 1'b1;
				ctrl.data = pad_val;
			end
			ST_COMP, ST_DONE: begin
				put = 1'b0;
			end
			default: begin
				put = 1'b0;
			end
		endcase
		full       = put && (fill_q == LAST_SLOT);
		ctrl.load  = put;
		ctrl.start = full;
		ctrl.init  = snap;
	end

	sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.done   (done),
		.chain  (chain)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			last_pend_q <= 1'b0;
			pad_first_q <= 1'b0;
			final_blk_q <= 1'b0;
			last_blk_q  <= 1'b0;
		end else begin
			if (put) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_present) begin
							len_q <= len_q + 64'd1;
						end
						if (full) begin
							state_q     <= ST_COMP;
							last_pend_q <= msg.end_of_message;
							pad_first_q <= msg.end_of_message;
						end else if (msg.end_of_message) begin
							state_q     <= ST_PAD;
							pad_first_q <= 1'b1;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					final_blk_q <= fb;
					if (full) begin
						state_q <= ST_COMP;
						if (fb) begin
							last_blk_q <= 1'b1;
						end else begin
							// The length goes into one more padding block.
							final_blk_q <= 1'b1;
							last_pend_q <= 1'b1;
						end
					end
				end
				ST_COMP: begin
					if (done) begin
						if (last_blk_q) begin
							state_q <= ST_DONE;
						end else if (last_pend_q) begin
							state_q     <= ST_PAD;
							last_pend_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DONE: begin
					if (snap) begin
						state_q     <= ST_IDLE;
						len_q       <= '0;
						last_blk_q  <= 1'b0;
						final_blk_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digest register.
	always_ff @(posedge clk) begin
		if (snap) begin
			dig_q <= chain;
		end
	end

	// Digest word counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (snap) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
		end else if (dig_acc) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign dig_valid       = busy_q;
	assign dig.digest_word = dig_q[{~cnt_q, 6'd0} +: 64];
	assign dig.word_number = cnt_q;
	assign dig.last_word   = (cnt_q == 2'd3);

	// Bytes reach the core only while collecting or padding.
	a_load_state: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> state_q == ST_IDLE || state_q == ST_PAD)
		else $error("byte loaded outside collect or pad");

	// A full block always goes to compression.
	a_full_comp: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> state_q == ST_COMP && fill_q == 6'd0)
		else $error("full block not compressed");

	// A digest is captured only into an empty output register.
	a_snap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		snap |=> busy_q && cnt_q == 2'd0 && state_q == ST_IDLE)
		else $error("digest capture overran output");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int unsigned HOLD_CYCLES  = 600;

	// SHA-256 round constants, round 0 first.
	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Chaining words at the start of every message.
	localparam logic [0:7][31:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Tracks the running hash of the current message and holds the digest
	// words that the block still owes.
	class digest_scoreboard;
		logic [0:7][31:0] chain;
		logic [7:0] blk [64];
		int unsigned fill;
		logic [63:0] length;
		sha_pkg::dig_req_t expected_q[$];
		int unsigned errors;

		function new();
			chain = START_HASH;
			fill = 0;
			length = '0;
			errors = 0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// One 64-round compression of the collected block into the chain.
		function void compress();
			logic [31:0] w [16];
			logic [0:7][31:0] v;
			logic [31:0] wv, w15, w2, s1, ch, t1, s0, mj, t2;
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
			v = chain;
			for (int r = 0; r < 64; r++) begin
				if (r < 16) begin
					wv = w[r];
				end else begin
					w15 = w[(r - 15) & 15];
					w2 = w[(r - 2) & 15];
					wv = w[r & 15] + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
						+ w[(r - 7) & 15] + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
					w[r & 15] = wv;
				end
				s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1 = v[7] + s1 + ch + ROUND_K[r] + wv;
				s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2 = s0 + mj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] = chain[i] + v[i];
		endfunction

		function void push_byte(logic [7:0] b);
			blk[fill] = b;
			fill++;
			if (fill == 64) begin
				compress();
				fill = 0;
			end
		endfunction

		// Takes in one accepted request; a closing request pads the message
		// and queues the four digest words.
		function void note_request(sha_pkg::msg_req_t req);
			logic [63:0] bits;
			sha_pkg::dig_req_t d;
			if (req.byte_present) begin
				length++;
				push_byte(req.message_byte);
			end
			if (!req.end_of_message)
				return;
			bits = length << 3;
			push_byte(8'h80);
			if (fill > 56)
				while (fill != 0) push_byte(8'h00);
			while (fill < 56)
				push_byte(8'h00);
			for (int k = 0; k < 8; k++)
				push_byte(bits[63 - 8 * k -: 8]);
			for (int k = 0; k < 4; k++) begin
				d.digest_word = {chain[2 * k], chain[2 * k + 1]};
				d.word_number = 2'(k);
				d.last_word = (k == 3);
				expected_q.insert(expected_q.size(), d);
			end
			chain = START_HASH;
			fill = 0;
			length = '0;
		endfunction

		task report(string what);
			$display("ERROR at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_digest(sha_pkg::dig_req_t got);
			sha_pkg::dig_req_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("digest word %h with none expected", got.digest_word));
				return;
			end
			want = expected_q.pop_front();
			if (got.digest_word !== want.digest_word)
				report($sformatf("digest_word %h, expected %h", got.digest_word,
					want.digest_word));
			if (got.word_number !== want.word_number)
				report($sformatf("word_number %0d, expected %0d", got.word_number,
					want.word_number));
			if (got.last_word !== want.last_word)
				report($sformatf("last_word %b, expected %b", got.last_word,
					want.last_word));
		endtask

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              msg_valid;
	logic              msg_stall;
	sha_pkg::msg_req_t msg;
	logic              dig_valid;
	logic              dig_stall;
	sha_pkg::dig_req_t dig;

	digest_scoreboard sb = new();

	int unsigned cycles;
	int unsigned real_items;
	bit sender_gaps;
	bit sender_quiet;
	bit pressure_go;
	bit pressure_done;
	int unsigned boundary_len [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

	sha256_stream_hasher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig       (dig)
	);

	always #5 clk = ~clk;

	// Pause length: mostly none, often short, now and then long.
	function automatic int unsigned pick_pause();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offers one request and holds it until the block takes it.
	task automatic offer(input logic [7:0] b, input logic present, input logic last);
		sha_pkg::msg_req_t req;
		int unsigned gap;
		req.message_byte = b;
		req.byte_present = present;
		req.end_of_message = last;
		msg <= req;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (msg_stall) @(posedge clk);
		sb.note_request(req);
		if (present || last)
			real_items++;
		gap = (sender_gaps && !sender_quiet) ? pick_pause() : 0;
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One whole message with random bytes and a few ignored requests mixed in.
	task automatic send_message(input int unsigned len);
		logic close_on_byte;
		int unsigned body;
		close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
		body = close_on_byte ? len - 1 : len;
		sender_gaps = ($urandom_range(0, 3) != 0);
		for (int unsigned i = 0; i < body; i++) begin
			if ($urandom_range(0, 19) == 0)
				offer(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			offer(8'($urandom_range(0, 255)), 1'b1, 1'b0);
		end
		offer(8'($urandom_range(0, 255)), close_on_byte, 1'b1);
	endtask

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Digest receiver: random stalls, calm stretches, and one long hold-off
	// that backs the block up into its input.
	initial begin
		int unsigned hold;
		int unsigned calm;
		int unsigned p;
		hold = 0;
		calm = 0;
		dig_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dig_valid && !dig_stall)
				sb.check_digest(dig);
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				dig_stall <= 1'b1;
			end else if (calm > 0) begin
				calm--;
				dig_stall <= 1'b0;
			end else if ($urandom_range(0, 29) == 0) begin
				calm = $urandom_range(30, 150);
				dig_stall <= 1'b0;
			end else begin
				p = pick_pause();
				hold = (p > 0) ? p - 1 : 0;
				dig_stall <= (p > 0);
			end
		end
	end

	// Reset, directed requests, then random messages, then drain.
	initial begin
		int unsigned r;
		int unsigned len;
		clk = 1'b0;
		arst_n = 1'b0;
		msg_valid = 1'b0;
		msg = '0;
		cycles = 0;
		real_items = 0;
		sender_gaps = 1'b1;
		sender_quiet = 1'b0;
		pressure_go = 1'b0;
		pressure_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Empty messages back to back; the byte field is ignored.
		offer(8'hff, 1'b0, 1'b1);
		offer(8'h00, 1'b0, 1'b1);
		// A request with neither flag does nothing.
		offer(8'h5a, 1'b0, 1'b0);
		// A byte that also closes its message.
		offer(8'h00, 1'b1, 1'b1);
		// A byte followed by an empty closing request.
		offer(8'hff, 1'b1, 1'b0);
		offer(8'h00, 1'b0, 1'b1);
		// "abc", closed on its last byte.
		offer(8'h61, 1'b1, 1'b0);
		offer(8'h62, 1'b1, 1'b0);
		offer(8'h63, 1'b1, 1'b1);
		// An ignored request inside a message.
		offer(8'h01, 1'b1, 1'b0);
		offer(8'ha5, 1'b0, 1'b0);
		offer(8'h80, 1'b1, 1'b0);
		offer(8'h7f, 1'b1, 1'b1);

		// Short messages sent flat out while the receiver holds off.
		pressure_go = 1'b1;
		sender_quiet = 1'b1;
		repeat (6) send_message($urandom_range(0, 3));
		sender_quiet = 1'b0;

		// Random messages, weighted toward the padding boundaries.
		while (real_items < 120) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				len = $urandom_range(0, 8);
			else if (r < 80)
				len = boundary_len[$urandom_range(0, 9)];
			else
				len = $urandom_range(9, 150);
			send_message(len);
		end
		if (msg_valid)
			msg_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
